### rtl/core/txhv_pkg.sv
// ----------------------------------------------------------------------------
// txhv_pkg
// Shared types and constants for the transaction header varint parser.
// ----------------------------------------------------------------------------
package txhv_pkg;

  localparam int NETWORK_BYTES    = 32;
  localparam int KEY_BYTES        = 32;
  localparam int MAX_VARINT_BYTES = 10;

  localparam int KEY_WORDS  = 4;
  localparam int CFG_IDX_W  = $clog2(KEY_WORDS);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_NET    = 4'd1,
    PH_MODULE = 4'd2,
    PH_ASSET  = 4'd3,
    PH_NONCE  = 4'd4,
    PH_FEE    = 4'd5,
    PH_KEYLEN = 4'd6,
    PH_KEY    = 4'd7,
    PH_DONE   = 4'd8
  } phase_t;

  typedef enum logic [3:0] {
    KIND_NET_BYTE   = 4'd0,
    KIND_MODULE     = 4'd1,
    KIND_ASSET      = 4'd2,
    KIND_NONCE      = 4'd3,
    KIND_FEE        = 4'd4,
    KIND_HEADER_OK  = 4'd5,
    KIND_BAD_KEYLEN = 4'd6,
    KIND_KEY_MISS   = 4'd7,
    KIND_VARINT_LONG = 4'd8
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
  } result_t;

  function automatic kind_t phase_kind(input phase_t ph);
    kind_t k;
    unique case (ph)
      PH_MODULE: k = KIND_MODULE;
      PH_ASSET:  k = KIND_ASSET;
      PH_NONCE:  k = KIND_NONCE;
      default:   k = KIND_FEE;
    endcase
    return k;
  endfunction

endpackage

### rtl/core/txhv_parser.sv
// ----------------------------------------------------------------------------
// txhv_parser
// Front end: takes one transaction byte per cycle when byte_vld is set, tracks the header phase,
// decodes varints, checks the key and pushes results into the queue.
// ----------------------------------------------------------------------------
module txhv_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_vld,
  input  logic [7:0]                    data_byte,
  input  logic                          start_req,
  input  logic                          cfg_we,
  input  logic [txhv_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [63:0]                   cfg_wdata,
  output logic                          push,
  output txhv_pkg::result_t             push_data
);

  txhv_pkg::phase_t phase_r, phase_nxt, cur_phase;
  logic [5:0]  byte_count_r, byte_count_nxt, cur_bc, bc_inc;
  logic [63:0] varint_acc_r, varint_acc_nxt, cur_acc, acc_or, shifted;
  logic [3:0]  varint_bytes_r, varint_bytes_nxt, cur_vb, vb_inc;
  logic        in_tag_r, in_tag_nxt, cur_tag;
  logic        key_differs_r, key_differs_nxt, cur_kd, kd_or;
  logic [63:0] expected_key_r [txhv_pkg::KEY_WORDS];
  logic [6:0]  shamt;
  logic [4:0]  key_idx;
  logic [63:0] key_word;
  logic [7:0]  want;
  logic        var_cont, var_long, net_end, key_end, len_ok;

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      expected_key_r[cfg_addr] <= cfg_wdata;
    end
    if (!rst_n) begin
      for (int i = 0; i < txhv_pkg::KEY_WORDS; i++) begin
        expected_key_r[i] <= '0;
      end
    end
  end

  always_comb begin
    cur_phase = start_req ? txhv_pkg::PH_NET : phase_r;
    cur_bc    = start_req ? 6'd0  : byte_count_r;
    cur_acc   = start_req ? 64'd0 : varint_acc_r;
    cur_vb    = start_req ? 4'd0  : varint_bytes_r;
    cur_tag   = start_req ? 1'b1  : in_tag_r;
    cur_kd    = start_req ? 1'b0  : key_differs_r;

    bc_inc   = cur_bc + 6'd1;
    net_end  = bc_inc >= 6'(txhv_pkg::NETWORK_BYTES);
    key_end  = bc_inc >= 6'(txhv_pkg::KEY_BYTES);

    shamt    = 7'({3'd0, cur_vb} * 7'd7);
    shifted  = (shamt < 7'd64) ? ({57'd0, data_byte[6:0]} << shamt[5:0]) : 64'd0;
    acc_or   = cur_acc | shifted;
    vb_inc   = cur_vb + 4'd1;
    var_cont = data_byte[7];
    var_long = vb_inc >= 4'(txhv_pkg::MAX_VARINT_BYTES);
    len_ok   = acc_or == 64'(txhv_pkg::KEY_BYTES);

    key_idx  = cur_bc[4:0];
    key_word = expected_key_r[key_idx[4:3]];
    want     = key_word[8*(7 - key_idx[2:0]) +: 8];
    kd_or    = cur_kd | (want != data_byte);
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (byte_vld) begin
      phase_nxt = cur_phase;
      unique case (cur_phase)
        txhv_pkg::PH_NET: begin
          if (net_end) phase_nxt = txhv_pkg::PH_MODULE;
        end
        txhv_pkg::PH_MODULE, txhv_pkg::PH_ASSET, txhv_pkg::PH_NONCE,
        txhv_pkg::PH_FEE, txhv_pkg::PH_KEYLEN: begin
          if (var_cont) begin
            if (var_long) phase_nxt = txhv_pkg::PH_DONE;
          end else if (!cur_tag) begin
            if (cur_phase == txhv_pkg::PH_KEYLEN) begin
              phase_nxt = len_ok ? txhv_pkg::PH_KEY : txhv_pkg::PH_DONE;
            end else begin
              phase_nxt = txhv_pkg::phase_t'(cur_phase + 4'd1);
            end
          end
        end
        txhv_pkg::PH_KEY: begin
          if (key_end) phase_nxt = txhv_pkg::PH_DONE;
        end
        default: phase_nxt = cur_phase;
      endcase
    end
  end

  // datapath and results
  always_comb begin
    byte_count_nxt   = byte_count_r;
    varint_acc_nxt   = varint_acc_r;
    varint_bytes_nxt = varint_bytes_r;
    in_tag_nxt       = in_tag_r;
    key_differs_nxt  = key_differs_r;
    push             = 1'b0;
    push_data.kind   = txhv_pkg::KIND_NET_BYTE;
    push_data.value  = 64'd0;
    if (byte_vld) begin
      byte_count_nxt   = cur_bc;
      varint_acc_nxt   = cur_acc;
      varint_bytes_nxt = cur_vb;
      in_tag_nxt       = cur_tag;
      key_differs_nxt  = cur_kd;
      unique case (cur_phase)
        txhv_pkg::PH_NET: begin
          push            = 1'b1;
          push_data.value = {56'd0, data_byte};
          byte_count_nxt  = net_end ? 6'd0 : bc_inc;
          if (net_end) begin
            varint_acc_nxt   = 64'd0;
            varint_bytes_nxt = 4'd0;
            in_tag_nxt       = 1'b1;
          end
        end
        txhv_pkg::PH_MODULE, txhv_pkg::PH_ASSET, txhv_pkg::PH_NONCE,
        txhv_pkg::PH_FEE, txhv_pkg::PH_KEYLEN: begin
          varint_acc_nxt   = acc_or;
          varint_bytes_nxt = vb_inc;
          if (var_cont) begin
            if (var_long) begin
              push           = 1'b1;
              push_data.kind = txhv_pkg::KIND_VARINT_LONG;
            end
          end else begin
            varint_acc_nxt   = 64'd0;
            varint_bytes_nxt = 4'd0;
            in_tag_nxt       = !cur_tag;
            if (!cur_tag) begin
              if (cur_phase == txhv_pkg::PH_KEYLEN) begin
                if (len_ok) begin
                  byte_count_nxt  = 6'd0;
                  key_differs_nxt = 1'b0;
                end else begin
                  push           = 1'b1;
                  push_data.kind = txhv_pkg::KIND_BAD_KEYLEN;
                end
              end else begin
                push            = 1'b1;
                push_data.kind  = txhv_pkg::phase_kind(cur_phase);
                push_data.value = (cur_phase == txhv_pkg::PH_MODULE ||
                                   cur_phase == txhv_pkg::PH_ASSET) ?
                                  {32'd0, acc_or[31:0]} : acc_or;
              end
            end
          end
        end
        txhv_pkg::PH_KEY: begin
          key_differs_nxt = kd_or;
          byte_count_nxt  = bc_inc;
          if (key_end) begin
            push           = 1'b1;
            push_data.kind = kd_or ? txhv_pkg::KIND_KEY_MISS : txhv_pkg::KIND_HEADER_OK;
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= txhv_pkg::PH_IDLE;
      byte_count_r   <= '0;
      varint_acc_r   <= '0;
      varint_bytes_r <= '0;
      in_tag_r       <= 1'b1;
      key_differs_r  <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      varint_acc_r   <= varint_acc_nxt;
      varint_bytes_r <= varint_bytes_nxt;
      in_tag_r       <= in_tag_nxt;
      key_differs_r  <= key_differs_nxt;
    end
  end

endmodule

### rtl/core/txhv_queue.sv
// ----------------------------------------------------------------------------
// txhv_queue
// Back end: short result queue whose head drives the output channel.
// ----------------------------------------------------------------------------
module txhv_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  txhv_pkg::result_t push_data,
  output logic              full,
  output logic              out_vld,
  input  logic              out_rdy,
  output txhv_pkg::result_t out_data
);

  txhv_pkg::result_t                mem_r [txhv_pkg::QDEPTH];
  logic [txhv_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [txhv_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             pop;

  assign full     = count_r == txhv_pkg::QCNT_W'(txhv_pkg::QDEPTH);
  assign out_vld  = count_r != '0;
  assign out_data = mem_r[rd_ptr_r];
  assign pop      = out_vld && out_rdy;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    priority if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/core/tx_header_varint_parser.sv
// ----------------------------------------------------------------------------
// tx_header_varint_parser
// Parses a transaction header byte by byte: network bytes, four varint
// fields, key length and key compare, with a result queue on the output.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction byte per word; in_tuser set marks the first byte
//           of a new transaction and restarts parsing at any time.
//   out_* : one word per network byte, decoded field or final status.
//   cfg_* : write the four expected key words while the block is idle.
// Timing:
//   One byte accepted per cycle while in_tready is high. A result is written
//   to the queue as the byte that produced it is accepted and appears on out_*
//   once it reaches the queue head; the rate is set by the parser state update.
// Reset:
//   Parser waits for a start byte, queue is empty, key words read zero.
// Stall:
//   A two-entry result queue absorbs output backpressure; in_tready falls
//   when it is full and rises once the receiver takes a word.
// ----------------------------------------------------------------------------
module tx_header_varint_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // data_byte
  input  logic                           in_tuser,   // start_req
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // field_value
  output logic [3:0]                     out_tuser,  // field_kind
  input  logic                           cfg_we,
  input  logic [txhv_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [63:0]                    cfg_wdata
);

  logic              full, push, byte_vld;
  txhv_pkg::result_t push_data, head;

  assign in_tready = !full;
  assign byte_vld  = in_tvalid && in_tready;

  txhv_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (byte_vld),
    .data_byte (in_tdata),
    .start_req (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_data (push_data)
  );

  txhv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_vld   (out_tvalid),
    .out_rdy   (out_tready),
    .out_data  (head)
  );

  assign out_tdata = head.value;
  assign out_tuser = head.kind;

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tx_header_varint_parser. Whole transactions are
// built as byte streams (network bytes, tag/value varints, key length, key)
// and pushed through the input stream. Every accepted byte goes through a
// behavioral copy of the parser, and each word on the output stream is
// checked against the oldest predicted field. A table of directed headers
// covers value extremes, truncation, bad lengths, key mismatches, overlong
// varints and restarts. Random headers follow under three idle patterns,
// with a new expected key loaded for each pattern.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]          NONE    = 8'hFF;
  localparam int                  SETTLE  = 6;
  localparam int                  PHASE_BYTES = 30;
  localparam int                  DIR_ROWS = 5;
  localparam logic [txhv_pkg::CFG_IDX_W-1:0] KEY_W0 = 0;
  localparam logic [txhv_pkg::CFG_IDX_W-1:0] KEY_W1 = 1;
  localparam logic [txhv_pkg::CFG_IDX_W-1:0] KEY_W2 = 2;
  localparam logic [txhv_pkg::CFG_IDX_W-1:0] KEY_W3 = 3;
  localparam logic [63:0]         ALL1    = '1;

  typedef struct packed {
    logic [63:0] mod;
    logic [63:0] asset;
    logic [63:0] nonce;
    logic [63:0] fee;
    logic [63:0] klen;
    logic [4:0]  wide;     // ten-byte encoding per value: mod..klen
    logic [7:0]  long_at;  // varint that never ends: 2*pair (+1 for value)
    logic [7:0]  flip;     // key byte to corrupt
    logic [7:0]  cut;      // bytes sent before a restart, 0 for none
    logic [3:0]  junk;     // bytes without start ahead of the header
    txhv_pkg::kind_t want;
  } hdr_t;

  localparam hdr_t DIR_TAB [DIR_ROWS] = '{
    '{64'hFFFF_FFFF_0000_0001, 64'h1_0000_0000, 64'h8000_0000_0000_0000, 64'd1,
      64'd32, 5'b11111, NONE, NONE, 8'd0, 4'd2, txhv_pkg::KIND_HEADER_OK},
    '{64'd127, 64'd128, 64'd16383, 64'd16384, 64'd32, 5'b0, NONE, 8'd0, 8'd0,
      4'd0, txhv_pkg::KIND_KEY_MISS},
    '{64'd1, 64'd2, 64'd3, 64'd4, ALL1, 5'b0, NONE, NONE, 8'd0, 4'd0,
      txhv_pkg::KIND_BAD_KEYLEN},
    '{64'd1, 64'd2, 64'd3, 64'd4, 64'd32, 5'b0, 8'd3, NONE, 8'd0, 4'd0,
      txhv_pkg::KIND_VARINT_LONG},
    '{64'd1, 64'd2, 64'd3, 64'd4, 64'd32, 5'b0, NONE, NONE, 8'd10, 4'd0,
      txhv_pkg::KIND_HEADER_OK}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // data_byte
  logic                 in_tuser;   // start_req
  logic                 out_tvalid;
  logic                 out_tready;
  logic [63:0]          out_tdata;  // field_value
  logic [3:0]           out_tuser;  // field_kind
  logic                 cfg_we;
  logic [txhv_pkg::CFG_IDX_W-1:0] cfg_addr;
  logic [63:0]          cfg_wdata;

  tx_header_varint_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // parser copy
  txhv_pkg::phase_t ph;
  logic [5:0]   cnt;
  logic [63:0]  acc;
  logic [3:0]   nvb;
  logic         want_tag;
  logic         key_bad;
  logic [255:0] key_cfg;
  txhv_pkg::result_t pending_fields [$];

  logic [7:0]   tx_bytes [$];
  txhv_pkg::result_t head;
  txhv_pkg::kind_t   last_status;
  int           in_gap_pct;
  int           out_gap_pct;
  int           bad_fields;
  int           n_fields;
  int           n_bytes;
  int           n_headers;
  int           n_ok, n_keylen, n_miss, n_long;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout with %0d fields outstanding", pending_fields.size());
    $display("== FAIL ==");
    $finish;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= out_gap_pct);

  task automatic emit_field(input txhv_pkg::kind_t k, input logic [63:0] v);
    pending_fields.push_back({k, v});
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic st);
    logic [63:0]      v;
    int               sh;
    txhv_pkg::kind_t  k;
    txhv_pkg::phase_t nxt;
    if (st) begin
      ph = txhv_pkg::PH_NET;
      cnt = '0;
      acc = '0;
      nvb = '0;
      want_tag = 1'b1;
      key_bad = 1'b0;
    end
    case (ph)
      txhv_pkg::PH_NET: begin
        cnt = cnt + 6'd1;
        if (cnt >= txhv_pkg::NETWORK_BYTES) begin
          ph = txhv_pkg::PH_MODULE;
          cnt = '0;
          acc = '0;
          nvb = '0;
          want_tag = 1'b1;
        end
        emit_field(txhv_pkg::KIND_NET_BYTE, {56'd0, b});
      end
      txhv_pkg::PH_MODULE, txhv_pkg::PH_ASSET, txhv_pkg::PH_NONCE, txhv_pkg::PH_FEE,
      txhv_pkg::PH_KEYLEN: begin
        sh = 7 * nvb;
        if (sh < 64) acc = acc | ({57'd0, b[6:0]} << sh);
        nvb = nvb + 4'd1;
        if (b[7]) begin
          if (nvb >= txhv_pkg::MAX_VARINT_BYTES) begin
            ph = txhv_pkg::PH_DONE;
            emit_field(txhv_pkg::KIND_VARINT_LONG, '0);
          end
        end else begin
          v = acc;
          acc = '0;
          nvb = '0;
          if (want_tag) begin
            want_tag = 1'b0;
          end else begin
            want_tag = 1'b1;
            if (ph == txhv_pkg::PH_KEYLEN) begin
              if (v != 64'(txhv_pkg::KEY_BYTES)) begin
                ph = txhv_pkg::PH_DONE;
                emit_field(txhv_pkg::KIND_BAD_KEYLEN, '0);
              end else begin
                ph = txhv_pkg::PH_KEY;
                cnt = '0;
                key_bad = 1'b0;
              end
            end else begin
              case (ph)
                txhv_pkg::PH_MODULE: begin
                  k = txhv_pkg::KIND_MODULE; nxt = txhv_pkg::PH_ASSET;
                end
                txhv_pkg::PH_ASSET: begin
                  k = txhv_pkg::KIND_ASSET;  nxt = txhv_pkg::PH_NONCE;
                end
                txhv_pkg::PH_NONCE: begin
                  k = txhv_pkg::KIND_NONCE;  nxt = txhv_pkg::PH_FEE;
                end
                default: begin
                  k = txhv_pkg::KIND_FEE;    nxt = txhv_pkg::PH_KEYLEN;
                end
              endcase
              if (ph == txhv_pkg::PH_MODULE || ph == txhv_pkg::PH_ASSET) v[63:32] = '0;
              ph = nxt;
              emit_field(k, v);
            end
          end
        end
      end
      txhv_pkg::PH_KEY: begin
        if (key_cfg[255 - 8 * cnt[4:0] -: 8] != b) key_bad = 1'b1;
        cnt = cnt + 6'd1;
        if (cnt >= txhv_pkg::KEY_BYTES) begin
          ph = txhv_pkg::PH_DONE;
          emit_field(key_bad ? txhv_pkg::KIND_KEY_MISS : txhv_pkg::KIND_HEADER_OK, '0);
        end
      end
      default: ;
    endcase
  endtask

  // check the oldest field first, then predict from the byte taken this edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (out_tuser >= txhv_pkg::KIND_HEADER_OK) last_status = txhv_pkg::kind_t'(out_tuser);
      if (pending_fields.size() == 0) begin
        bad_fields++;
        $display("%0t: expected no word, got kind %0d value %h", $time, out_tuser, out_tdata);
      end else begin
        head = pending_fields.pop_front();
        n_fields++;
        case (head.kind)
          txhv_pkg::KIND_HEADER_OK:   n_ok++;
          txhv_pkg::KIND_BAD_KEYLEN:  n_keylen++;
          txhv_pkg::KIND_KEY_MISS:    n_miss++;
          txhv_pkg::KIND_VARINT_LONG: n_long++;
          default: ;
        endcase
        if (out_tuser !== head.kind || out_tdata !== head.value) begin
          bad_fields++;
          $display("%0t: expected kind %0d value %h, got kind %0d value %h",
                   $time, head.kind, head.value, out_tuser, out_tdata);
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) parse_byte(in_tdata, in_tuser);
  end

  task automatic send_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= st;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_bytes++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_fields.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [txhv_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= d;
    @(negedge clk);
  endtask

  task automatic load_key(input logic [255:0] k);
    cfg_write(KEY_W0, k[255:192]);
    cfg_write(KEY_W1, k[191:128]);
    cfg_write(KEY_W2, k[127:64]);
    cfg_write(KEY_W3, k[63:0]);
    cfg_we <= 1'b0;
    key_cfg = k;
  endtask

  task automatic put_varint(input logic [63:0] v, input logic wide, input logic over);
    logic [7:0]  b;
    logic [63:0] r;
    int          i;
    r = v;
    if (over) begin
      repeat (txhv_pkg::MAX_VARINT_BYTES) begin
        b = 8'($urandom);
        b[7] = 1'b1;
        tx_bytes.push_back(b);
      end
    end else if (wide) begin
      for (i = 0; i < 9; i++) tx_bytes.push_back({1'b1, v[7 * i +: 7]});
      b = 8'($urandom);
      // upper payload bits of the last byte fall beyond bit 63
      tx_bytes.push_back({1'b0, b[5:0], v[63]});
    end else begin
      do begin
        b = {1'b0, r[6:0]};
        r = r >> 7;
        if (r != 0) b[7] = 1'b1;
        tx_bytes.push_back(b);
      end while (r != 0);
    end
  endtask

  task automatic build_tx(input hdr_t h);
    logic [63:0] vals [5];
    logic [7:0]  b;
    int          i;
    vals[0] = h.mod;
    vals[1] = h.asset;
    vals[2] = h.nonce;
    vals[3] = h.fee;
    vals[4] = h.klen;
    tx_bytes.delete();
    repeat (txhv_pkg::NETWORK_BYTES) begin
      b = 8'($urandom);
      tx_bytes.push_back(b);
    end
    for (i = 0; i < 5; i++) begin
      put_varint(64'($urandom_range(0, 16383)), 1'b0, h.long_at == 2 * i);
      if (h.long_at == 2 * i) return;
      put_varint(vals[i], h.wide[i], h.long_at == 2 * i + 1);
      if (h.long_at == 2 * i + 1) return;
    end
    if (h.klen != 64'(txhv_pkg::KEY_BYTES)) return;
    for (i = 0; i < txhv_pkg::KEY_BYTES; i++) begin
      b = key_cfg[255 - 8 * i -: 8];
      if (h.flip == i) b = b ^ 8'($urandom_range(1, 255));
      tx_bytes.push_back(b);
    end
  endtask

  task automatic send_tx(input hdr_t h);
    logic [7:0] b;
    int         i;
    repeat (h.junk) begin
      b = 8'($urandom);
      send_byte(b, 1'b0);
    end
    build_tx(h);
    if (h.cut != 0 && h.cut < tx_bytes.size())
      for (i = 0; i < h.cut; i++) send_byte(tx_bytes[i], i == 0);
    for (i = 0; i < tx_bytes.size(); i++) send_byte(tx_bytes[i], i == 0);
    n_headers++;
  endtask

  function automatic logic [63:0] rand_val();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(7) == 0) return ALL1;
    return r >> $urandom_range(0, 63);
  endfunction

  task automatic rand_tx();
    hdr_t h;
    h.mod     = rand_val();
    h.asset   = rand_val();
    h.nonce   = rand_val();
    h.fee     = rand_val();
    h.klen    = 64'(txhv_pkg::KEY_BYTES);
    h.wide    = 5'($urandom) & 5'($urandom) & 5'($urandom);
    h.long_at = NONE;
    h.flip    = NONE;
    h.cut     = '0;
    h.junk    = 4'($urandom_range(0, 3));
    h.want    = txhv_pkg::KIND_HEADER_OK;
    case ($urandom_range(0, 9))
      0: h.long_at = 8'($urandom_range(0, 9));
      1: h.klen = $urandom_range(1) ? 64'($urandom_range(0, 63)) : rand_val();
      2: h.flip = 8'($urandom_range(0, txhv_pkg::KEY_BYTES - 1));
      3: h.cut = 8'($urandom_range(1, 120));
      default: ;
    endcase
    send_tx(h);
  endtask

  initial begin
    int r;
    int p;
    int start_bytes;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    out_tready  = 1'b0;
    rst_n       = 1'b0;
    key_cfg     = '0;
    ph          = txhv_pkg::PH_IDLE;
    cnt         = '0;
    acc         = '0;
    nvb         = '0;
    want_tag    = 1'b1;
    key_bad     = 1'b0;
    last_status = txhv_pkg::KIND_NET_BYTE;
    in_gap_pct  = 29;
    out_gap_pct = 52;
    bad_fields  = 0;
    n_fields    = 0;
    n_bytes     = 0;
    n_headers   = 0;
    n_ok = 0; n_keylen = 0; n_miss = 0; n_long = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_key(256'h0011223344556677_8899AABBCCDDEEFF_0123456789ABCDEF_FEDCBA98765432FF);
    for (r = 0; r < DIR_ROWS; r++) begin
      last_status = txhv_pkg::KIND_NET_BYTE;
      send_tx(DIR_TAB[r]);
      settle();
      if (last_status != DIR_TAB[r].want) begin
        bad_fields++;
        $display("%0t: header %0d expected status %0d, got %0d",
                 $time, r, DIR_TAB[r].want, last_status);
      end
    end

    for (p = 0; p < 3; p++) begin
      in_gap_pct  = (p == 0) ? 29 : (p == 1) ? 52 : 0;
      out_gap_pct = (p == 0) ? 52 : (p == 1) ? 29 : 0;
      settle();
      case (p)
        0: load_key('0);
        1: load_key('1);
        default: load_key({$urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom});
      endcase
      start_bytes = n_bytes;
      while (n_bytes - start_bytes < PHASE_BYTES) rand_tx();
    end
    settle();

    $display("run: %0d bytes in %0d headers, %0d words checked",
             n_bytes, n_headers, n_fields);
    $display("statuses: %0d ok, %0d bad length, %0d key mismatch, %0d overlong",
             n_ok, n_keylen, n_miss, n_long);
    if (bad_fields == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
